// ===== hdl/weir_pkg.sv =====
// ----------------------------------------------------------------------------
// weir_pkg
// shared constants and the work record of the weir discharge pipeline
// ----------------------------------------------------------------------------
package weir_pkg;

    localparam int DIV_STEPS = 4;                       // quotient bits per divider stage
    localparam int DIV_STG   = 64 / DIV_STEPS;          // divider stages
    localparam int SQ_STG    = 32;                      // one root bit per stage
    localparam int NSTG      = 4 + DIV_STG + 1 + SQ_STG + 5;

    localparam logic [2:0] DIR_BOTH  = 3'd0;
    localparam logic [2:0] DIR_NORTH = 3'd1;
    localparam logic [2:0] DIR_EAST  = 3'd2;
    localparam logic [2:0] DIR_SOUTH = 3'd3;
    localparam logic [2:0] DIR_WEST  = 3'd4;

    localparam logic [30:0] THR_RESET    = 31'd66;
    localparam logic [47:0] FLOW_POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] FLOW_NEG_MAX = 48'h8000_0000_0000;

    typedef struct packed {
        logic        wr;
        logic        act;
        logic        neg;
        logic        free;
        logic [32:0] hu;
        logic [34:0] c;
        logic [15:0] m;
        logic [63:0] sh;    // operand bits still to be consumed
        logic [63:0] acc;   // quotient, later root
        logic [34:0] rm;    // partial remainder
    } t_work;

endpackage

// ===== hdl/weir_if.sv =====
// ----------------------------------------------------------------------------
// weir edge channels
// valid/ready channels for edge requests and discharge results
// ----------------------------------------------------------------------------
interface weir_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] bed_near;
    logic        [30:0] depth_near;
    logic signed [31:0] bed_far;
    logic        [30:0] depth_far;
    logic signed [31:0] crest_level;
    logic        [15:0] discharge_coeff;
    logic        [30:0] crest_width;
    logic        [15:0] modular_limit;
    logic        [2:0]  fixed_direction;
    logic               is_bridge;
    logic               axis_is_y;
    logic               link_present;

    modport source (
        output valid, bed_near, depth_near, bed_far, depth_far, crest_level,
               discharge_coeff, crest_width, modular_limit, fixed_direction,
               is_bridge, axis_is_y, link_present,
        input  ready
    );
    modport sink (
        input  valid, bed_near, depth_near, bed_far, depth_far, crest_level,
               discharge_coeff, crest_width, modular_limit, fixed_direction,
               is_bridge, axis_is_y, link_present,
        output ready
    );
endinterface

interface weir_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] flow;
    logic               write_flow;

    modport source (output valid, flow, write_flow, input ready);
    modport sink (input valid, flow, write_flow, output ready);
endinterface

// ===== hdl/weir_edge_discharge.sv =====
// ----------------------------------------------------------------------------
// weir_edge_discharge
// broad-crested weir discharge across one grid edge, free and drowned flow
// ----------------------------------------------------------------------------
// Takes one edge request per clock while ready is high and returns one result
// per request, in order, through 58 register stages. The pipeline depth is set
// by the pipelined long divider for the drowned ratio (16 stages of 4 bits)
// followed by the square root unit (32 stages, one root bit each); decode,
// head terms and the split Q16.16 multiplies add 10 stages. The whole
// pipeline advances whenever the output register is empty or being taken,
// so a stalled result holds all stages and ready drops only while the output
// is full and not taken.
// The depth threshold may be written only while the pipeline is empty.
module weir_edge_discharge
    import weir_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_data,
    weir_in_if.sink     i_edge,
    weir_out_if.source  o_res
);

    logic [30:0]     r_thr;
    logic [NSTG-1:0] r_vld;
    logic            en;

    assign en           = !r_vld[NSTG-1] || o_res.ready;
    assign i_edge.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
            r_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (en) begin
                r_vld <= {r_vld[NSTG-2:0], i_edge.valid};
            end
        end
    end

    // stage a: surfaces, gating and direction
    logic signed [32:0] s0, s1, hc;
    logic [2:0]         pos_dir, neg_dir;
    logic               eval, go_pos, go_neg;

    always_comb begin
        s0      = 33'(i_edge.bed_near) + $signed({2'b00, i_edge.depth_near});
        s1      = 33'(i_edge.bed_far) + $signed({2'b00, i_edge.depth_far});
        hc      = 33'(i_edge.crest_level);
        eval    = (i_edge.depth_near > r_thr || i_edge.depth_far > r_thr)
                  && i_edge.link_present;
        pos_dir = i_edge.axis_is_y ? DIR_SOUTH : DIR_EAST;
        neg_dir = i_edge.axis_is_y ? DIR_NORTH : DIR_WEST;
        go_pos  = s0 > s1 && s0 > hc && i_edge.depth_near != '0
                  && (i_edge.fixed_direction == DIR_BOTH
                      || i_edge.fixed_direction == pos_dir);
        go_neg  = s1 > s0 && s1 > hc && i_edge.depth_far != '0
                  && (i_edge.fixed_direction == DIR_BOTH
                      || i_edge.fixed_direction == neg_dir);
    end

    logic               r_a_wr, r_a_act, r_a_neg;
    logic signed [32:0] r_a_sup, r_a_sdn, r_a_hc;
    logic [15:0]        r_a_cd, r_a_m;
    logic [30:0]        r_a_w;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_wr  <= eval;
            r_a_act <= eval && !i_edge.is_bridge && (go_pos || go_neg);
            r_a_neg <= !go_pos;
            r_a_sup <= go_pos ? s0 : s1;
            r_a_sdn <= go_pos ? s1 : s0;
            r_a_hc  <= hc;
            r_a_cd  <= i_edge.discharge_coeff;
            r_a_w   <= i_edge.crest_width;
            r_a_m   <= (i_edge.modular_limit == '0) ? 16'd1 : i_edge.modular_limit;
        end
    end

    // stage b: heads over the crest, coefficient times width
    logic signed [33:0] hu_b, hd_b;
    logic [46:0]        cw_b;

    always_comb begin
        hu_b = 34'(r_a_sup) - 34'(r_a_hc);
        hd_b = 34'(r_a_sdn) - 34'(r_a_hc);
        cw_b = 47'(r_a_cd) * 47'(r_a_w);
    end

    logic               r_b_wr, r_b_act, r_b_neg;
    logic [32:0]        r_b_hu;
    logic signed [33:0] r_b_hd;
    logic [34:0]        r_b_c;
    logic [15:0]        r_b_m;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_wr  <= r_a_wr;
            r_b_act <= r_a_act;
            r_b_neg <= r_a_neg;
            r_b_hu  <= hu_b[32:0];
            r_b_hd  <= hd_b;
            r_b_c   <= cw_b[46:12];
            r_b_m   <= r_a_m;
        end
    end

    // stage c: m*hu for the drowning test, head difference
    logic [33:0] d_c;
    assign d_c = {1'b0, r_b_hu} - r_b_hd;

    logic               r_c_wr, r_c_act, r_c_neg;
    logic [32:0]        r_c_hu, r_c_d;
    logic signed [33:0] r_c_hd;
    logic [48:0]        r_c_mhu;
    logic [34:0]        r_c_c;
    logic [15:0]        r_c_m;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_wr  <= r_b_wr;
            r_c_act <= r_b_act;
            r_c_neg <= r_b_neg;
            r_c_hu  <= r_b_hu;
            r_c_d   <= d_c[32:0];
            r_c_hd  <= r_b_hd;
            r_c_mhu <= 49'(r_b_m) * 49'(r_b_hu);
            r_c_c   <= r_b_c;
            r_c_m   <= r_b_m;
        end
    end

    // stage d: free/drowned decision, divider setup
    t_work n_d, r_d;

    always_comb begin
        n_d      = '0;
        n_d.wr   = r_c_wr;
        n_d.act  = r_c_act;
        n_d.neg  = r_c_neg;
        n_d.free = r_c_hd[33] || ({2'b00, r_c_hd[32:0], 14'b0} < r_c_mhu);
        n_d.hu   = r_c_hu;
        n_d.c    = r_c_c;
        n_d.m    = r_c_m;
        n_d.sh   = {1'b0, r_c_d, 30'b0};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d <= n_d;
        end
    end

    // divider: floor((hu-hd)*2^30 / m), restoring, DIV_STEPS bits per stage
    function automatic t_work div_step(input t_work x);
        t_work       y;
        logic [16:0] rem;
        logic        qb;
        y = x;
        for (int k = 0; k < DIV_STEPS; k++) begin
            rem  = {y.rm[15:0], y.sh[63]};
            y.sh = {y.sh[62:0], 1'b0};
            qb   = rem >= {1'b0, y.m};
            if (qb) begin
                rem = rem - {1'b0, y.m};
            end
            y.rm  = {18'b0, rem};
            y.acc = {y.acc[62:0], qb};
        end
        return y;
    endfunction

    t_work r_dv [DIV_STG];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0] <= div_step(r_d);
            for (int i = 1; i < DIV_STG; i++) begin
                r_dv[i] <= div_step(r_dv[i-1]);
            end
        end
    end

    // stage e: pick the square root operand
    t_work n_e, r_e;

    always_comb begin
        n_e     = r_dv[DIV_STG-1];
        n_e.sh  = r_dv[DIV_STG-1].free ? {15'b0, r_dv[DIV_STG-1].hu, 16'b0}
                                       : r_dv[DIV_STG-1].acc;
        n_e.acc = '0;
        n_e.rm  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e <= n_e;
        end
    end

    // integer square root, one root bit per stage
    function automatic t_work sq_step(input t_work x);
        t_work       y;
        logic [35:0] rem, trial;
        logic        rb;
        y     = x;
        rem   = {x.rm[33:0], x.sh[63:62]};
        trial = {2'b00, x.acc[31:0], 2'b01};
        rb    = rem >= trial;
        if (rb) begin
            rem = rem - trial;
        end
        y.sh  = {x.sh[61:0], 2'b00};
        y.rm  = rem[34:0];
        y.acc = {x.acc[62:0], rb};
        return y;
    endfunction

    t_work r_sq [SQ_STG];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq[0] <= sq_step(r_e);
            for (int i = 1; i < SQ_STG; i++) begin
                r_sq[i] <= sq_step(r_sq[i-1]);
            end
        end
    end

    // stage f: hu * root in two halves
    t_work       sq_o;
    assign sq_o = r_sq[SQ_STG-1];

    logic        r_f_wr, r_f_act, r_f_neg;
    logic [34:0] r_f_c;
    logic [48:0] r_f_plo, r_f_phi;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_wr  <= sq_o.wr;
            r_f_act <= sq_o.act;
            r_f_neg <= sq_o.neg;
            r_f_c   <= sq_o.c;
            r_f_plo <= 49'(sq_o.hu) * 49'(sq_o.acc[15:0]);
            r_f_phi <= 49'(sq_o.hu) * 49'(sq_o.acc[31:16]);
        end
    end

    // stage g: p = hu*root >> 16
    logic [65:0] p_g;
    assign p_g = {1'b0, r_f_phi, 16'b0} + 66'(r_f_plo);

    logic        r_g_wr, r_g_act, r_g_neg;
    logic [34:0] r_g_c;
    logic [48:0] r_g_p;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_wr  <= r_f_wr;
            r_g_act <= r_f_act;
            r_g_neg <= r_f_neg;
            r_g_c   <= r_f_c;
            r_g_p   <= p_g[64:16];
        end
    end

    // stage h: c * p as three partial products
    logic        r_h_wr, r_h_act, r_h_neg;
    logic [51:0] r_h_pp0;
    logic [50:0] r_h_pp1, r_h_pp2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_wr  <= r_g_wr;
            r_h_act <= r_g_act;
            r_h_neg <= r_g_neg;
            r_h_pp0 <= 52'(r_g_c) * 52'(r_g_p[16:0]);
            r_h_pp1 <= 51'(r_g_c) * 51'(r_g_p[32:17]);
            r_h_pp2 <= 51'(r_g_c) * 51'(r_g_p[48:33]);
        end
    end

    // stage i: sum partial products, drop 16 fraction bits
    logic [83:0] prod_i;
    assign prod_i = 84'(r_h_pp0) + {16'b0, r_h_pp1, 17'b0} + {r_h_pp2, 33'b0};

    logic        r_i_wr, r_i_act, r_i_neg;
    logic [67:0] r_i_mag;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_wr  <= r_h_wr;
            r_i_act <= r_h_act;
            r_i_neg <= r_h_neg;
            r_i_mag <= prod_i[83:16];
        end
    end

    // stage j: saturate, sign, output register
    logic [47:0] n_flow;

    always_comb begin
        if (!r_i_wr || !r_i_act) begin
            n_flow = '0;
        end else if (r_i_neg) begin
            n_flow = (r_i_mag >= 68'(FLOW_NEG_MAX)) ? FLOW_NEG_MAX : -r_i_mag[47:0];
        end else begin
            n_flow = (r_i_mag > 68'(FLOW_POS_MAX)) ? FLOW_POS_MAX : r_i_mag[47:0];
        end
    end

    logic [47:0] r_flow;
    logic        r_wr;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_flow <= n_flow;
            r_wr   <= r_i_wr;
        end
    end

    assign o_res.valid      = r_vld[NSTG-1];
    assign o_res.flow       = r_flow;
    assign o_res.write_flow = r_wr;

`ifndef SYNTH
    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.write_flow |-> o_res.flow == '0)
        else $error("flow nonzero on an edge that is not written");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_res.valid)
        else $error("result valid right after reset");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4 + DIV_STG - 1] |-> r_dv[DIV_STG-1].rm < 35'(r_dv[DIV_STG-1].m))
        else $error("divider remainder not below divisor");

    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4 + DIV_STG + SQ_STG] |-> sq_o.rm <= {2'b00, sq_o.acc[31:0], 1'b0})
        else $error("square root remainder above twice the root");
`endif

endmodule
